// ===== sv/baro_temp_pressure_compensation_top_assert.svh =====
// assertion macros for the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define BTPC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent now implies consequent at the next edge
`define BTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/btpc_pkg.sv =====
// types, constants and calibration unpacking for the compensation block
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned MulLat   = 4;
  localparam int unsigned TempLat  = 2 * MulLat + 3;
  localparam int unsigned PressLat = 4 * MulLat + 5;

  typedef enum logic [2:0] {
    CFG_CALIB_LOW     = 3'd0,
    CFG_CALIB_MID     = 3'd1,
    CFG_CALIB_HIGH    = 3'd2,
    CFG_TEMP_FLOOR    = 3'd3,
    CFG_TEMP_CEILING  = 3'd4,
    CFG_PRESS_FLOOR   = 3'd5,
    CFG_PRESS_CEILING = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_TEMP  = 2'd1,
    MODE_PRESS = 2'd2,
    MODE_BOTH  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_out;
    logic [22:0]        pressure_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        u0;
    logic [15:0]        u2;
    logic signed [7:0]  s4;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  function automatic coef_t calib_unpack(input logic [63:0] lo, input logic [63:0] mid,
                                         input logic [39:0] hi);
    coef_t c;
    c.u0  = lo[15:0];
    c.u2  = lo[31:16];
    c.s4  = signed'(lo[39:32]);
    c.p1  = 17'(signed'(lo[55:40])) - 17'sd16384;
    c.p2  = 17'(signed'({mid[7:0], lo[63:56]})) - 17'sd16384;
    c.p3  = signed'(mid[15:8]);
    c.p4  = signed'(mid[23:16]);
    c.p5  = mid[39:24];
    c.p6  = mid[55:40];
    c.p7  = signed'(mid[63:56]);
    c.p8  = signed'(hi[7:0]);
    c.p9  = signed'(hi[23:8]);
    c.p10 = signed'(hi[31:24]);
    c.p11 = signed'(hi[39:32]);
    return c;
  endfunction

endpackage

// ===== sv/baro_temp_pressure_compensation_top.sv =====
// Barometric temperature and pressure compensation, top level. One word is taken per
// cycle while the output is not stalled, and its result passes through six four-stage
// multiplier passes plus the add, clamp and output registers; throughput is one word a
// cycle, set by the fully pipelined 32x32 partial-product multipliers. A stall on a held
// output word freezes the whole pipeline. Calibration and clamp registers are written through
// the configuration port, always ready, and must only change while no word is in flight.
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_top_assert.svh"
module baro_temp_pressure_compensation_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  btpc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output btpc_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  import btpc_pkg::*;

  logic [63:0]        calib_low_q, calib_mid_q;
  logic [39:0]        calib_high_q;
  logic signed [15:0] temp_floor_q, temp_ceiling_q;
  logic [22:0]        press_floor_q, press_ceiling_q;
  coef_t              coef;
  logic               en;
  logic               temp_valid, press_valid;
  logic signed [55:0] t_lin;
  logic [1:0]         mode_t;
  logic [23:0]        x_t;
  logic [1:0]         mode_p;
  logic [15:0]        tout_p;
  logic [22:0]        press;
  logic               out_valid_q;
  out_word_t          out_word_d, out_word_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_low_q     <= '0;
      calib_mid_q     <= '0;
      calib_high_q    <= '0;
      temp_floor_q    <= -16'sd10240;
      temp_ceiling_q  <= 16'sd21760;
      press_floor_q   <= 23'd1920000;
      press_ceiling_q <= 23'd8000000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CALIB_LOW:     calib_low_q     <= cfg_data_i;
        CFG_CALIB_MID:     calib_mid_q     <= cfg_data_i;
        CFG_CALIB_HIGH:    calib_high_q    <= cfg_data_i[39:0];
        CFG_TEMP_FLOOR:    temp_floor_q    <= signed'(cfg_data_i[15:0]);
        CFG_TEMP_CEILING:  temp_ceiling_q  <= signed'(cfg_data_i[15:0]);
        CFG_PRESS_FLOOR:   press_floor_q   <= cfg_data_i[22:0];
        CFG_PRESS_CEILING: press_ceiling_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  assign coef       = calib_unpack(calib_low_q, calib_mid_q, calib_high_q);
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  btpc_temp u_temp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .raw_temperature_i(in_word_i.raw_temperature), .coef_i(coef),
    .temp_floor_i(temp_floor_q), .temp_ceiling_i(temp_ceiling_q),
    .valid_o(temp_valid), .t_o(t_lin)
  );

  btpc_delay #(.W(26), .N(TempLat)) u_dly_side (
    .clk_i, .en_i(en), .d_i({in_word_i.mode, in_word_i.raw_pressure}),
    .q_o({mode_t, x_t})
  );

  btpc_press u_press (
    .clk_i, .rst_ni, .en_i(en), .valid_i(temp_valid), .t_i(t_lin), .x_i(x_t),
    .coef_i(coef), .press_floor_i(press_floor_q), .press_ceiling_i(press_ceiling_q),
    .valid_o(press_valid), .press_o(press)
  );

  btpc_delay #(.W(18), .N(PressLat)) u_dly_temp (
    .clk_i, .en_i(en), .d_i({mode_t, t_lin[55:40]}), .q_o({mode_p, tout_p})
  );

  always_comb begin
    out_word_d = '0;
    case (mode_e'(mode_p))
      MODE_TEMP:  out_word_d.temperature_out = signed'(tout_p);
      MODE_PRESS: out_word_d.pressure_out = press;
      MODE_BOTH: begin
        out_word_d.temperature_out = signed'(tout_p);
        out_word_d.pressure_out    = press;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= press_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // empty output register never holds the input back
  `BTPC_ASSERT_NOW(a_empty_no_stall, !out_valid_o -> !in_stall_o, "stall with empty output")
  // a result only appears when the pipeline delivered one
  `BTPC_ASSERT_NOW(a_rose_from_pipe, $rose(out_valid_o) -> $past(press_valid), "spurious word")
  // a stall freezes the pipeline tail
  `BTPC_ASSERT_NEXT(a_stall_freeze, in_stall_o, $stable(press_valid), "pipeline moved in stall")

endmodule

// ===== sv/btpc_delay.sv =====
// shift line that keeps side data aligned with the multiplier stages
`timescale 1ns / 1ps
module btpc_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        sr_q[k] <= sr_q[k-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

// ===== sv/btpc_mul.sv =====
// four-stage signed multiplier built from registered 32x32 partial products
`timescale 1ns / 1ps
module btpc_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned LA  = (WA + 31) / 32;
  localparam int unsigned LB  = (WB + 31) / 32;
  localparam int unsigned WMA = LA * 32;
  localparam int unsigned WMB = LB * 32;
  localparam int unsigned WP  = WA + WB;
  localparam int unsigned WS  = (LA + LB) * 32;

  logic [WA-1:0]  abs_a;
  logic [WB-1:0]  abs_b;
  logic [WMA-1:0] ma_q;
  logic [WMB-1:0] mb_q;
  logic           neg1_q, neg2_q, neg3_q;
  logic [63:0]    pp_d [LA*LB];
  logic [63:0]    pp_q [LA*LB];
  logic [WS-1:0]  acc;
  logic [WP-1:0]  mag_q;
  logic signed [WP-1:0] p_q;

  assign abs_a = a_i[WA-1] ? WA'(~a_i + 1'b1) : a_i;
  assign abs_b = b_i[WB-1] ? WB'(~b_i + 1'b1) : b_i;

  always_comb begin
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        pp_d[i*LB+j] = 64'(ma_q[32*i +: 32]) * 64'(mb_q[32*j +: 32]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        acc = acc + (WS'(pp_q[i*LB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= WMA'(abs_a);
      mb_q   <= WMB'(abs_b);
      neg1_q <= a_i[WA-1] ^ b_i[WB-1];
      pp_q   <= pp_d;
      neg2_q <= neg1_q;
      mag_q  <= acc[WP-1:0];
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? WP'(~mag_q + 1'b1) : mag_q;
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/btpc_temp.sv =====
// quadratic temperature linearisation and clamp
`timescale 1ns / 1ps
module btpc_temp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [23:0]         raw_temperature_i,
  input  btpc_pkg::coef_t     coef_i,
  input  logic signed [15:0]  temp_floor_i,
  input  logic signed [15:0]  temp_ceiling_i,
  output logic                valid_o,
  output logic signed [55:0]  t_o
);
  import btpc_pkg::*;

  logic [TempLat-1:0]  v_q;
  logic signed [24:0]  d_q;
  logic signed [24:0]  d_dly;
  logic signed [32:0]  ds4;
  logic signed [35:0]  inner_q;
  logic signed [60:0]  tl;
  logic signed [60:0]  lo, hi, t1, t2;
  logic signed [55:0]  t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[TempLat-2:0], valid_i};
    end
  end

  btpc_mul #(.WA(25), .WB(8)) u_mul_ds4 (
    .clk_i, .en_i, .a_i(d_q), .b_i(signed'(coef_i.s4)), .p_o(ds4)
  );

  btpc_delay #(.W(25), .N(MulLat + 1)) u_dly_d (
    .clk_i, .en_i, .d_i(d_q), .q_o(d_dly)
  );

  btpc_mul #(.WA(25), .WB(36)) u_mul_tl (
    .clk_i, .en_i, .a_i(d_dly), .b_i(inner_q), .p_o(tl)
  );

  assign lo = 61'(signed'({temp_floor_i, 40'b0}));
  assign hi = 61'(signed'({temp_ceiling_i, 40'b0}));
  assign t1 = (tl < lo) ? lo : tl;
  assign t2 = (t1 > hi) ? hi : t1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q     <= signed'({1'b0, raw_temperature_i}) - signed'({1'b0, coef_i.u0, 8'b0});
      inner_q <= signed'({2'b0, coef_i.u2, 18'b0}) + 36'(ds4);
      t_q     <= t2[55:0];
    end
  end

  assign valid_o = v_q[TempLat-1];
  assign t_o     = t_q;

endmodule

// ===== sv/btpc_press.sv =====
// cubic pressure polynomial in horner form and clamp
`timescale 1ns / 1ps
module btpc_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [55:0]  t_i,
  input  logic [23:0]         x_i,
  input  btpc_pkg::coef_t     coef_i,
  input  logic [22:0]         press_floor_i,
  input  logic [22:0]         press_ceiling_i,
  output logic                valid_o,
  output logic [22:0]         press_o
);
  import btpc_pkg::*;

  logic [PressLat-1:0] v_q;
  logic signed [24:0]  x0, x1, x2, x3;
  logic signed [55:0]  t1, t2;
  logic signed [63:0]  a0, a1, a2;
  logic signed [32:0]  xp;
  logic signed [63:0]  b0_q, b1_q;
  logic signed [65:0]  c2_q;
  logic signed [119:0] c0, c1;
  logic signed [90:0]  xc2, xc2_dly;
  logic signed [122:0] d0_q;
  logic signed [121:0] d1_q;
  logic signed [178:0] e0;
  logic signed [177:0] e1;
  logic signed [179:0] f0_q, f0_dly, r1_q;
  logic signed [204:0] xr;
  logic signed [205:0] total;
  logic signed [30:0]  q_q, fl, ce, q1, q2;
  logic [22:0]         press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[PressLat-2:0], valid_i};
    end
  end

  assign x0 = signed'({1'b0, x_i});

  btpc_mul #(.WA(8), .WB(56)) u_mul_a0 (
    .clk_i, .en_i, .a_i(signed'(coef_i.p8)), .b_i(t_i), .p_o(a0)
  );
  btpc_mul #(.WA(8), .WB(56)) u_mul_a1 (
    .clk_i, .en_i, .a_i(signed'(coef_i.p4)), .b_i(t_i), .p_o(a1)
  );
  btpc_mul #(.WA(8), .WB(56)) u_mul_a2 (
    .clk_i, .en_i, .a_i(signed'(coef_i.p10)), .b_i(t_i), .p_o(a2)
  );
  btpc_mul #(.WA(25), .WB(8)) u_mul_xp (
    .clk_i, .en_i, .a_i(x0), .b_i(signed'(coef_i.p11)), .p_o(xp)
  );
  btpc_delay #(.W(81), .N(MulLat + 1)) u_dly_tx1 (
    .clk_i, .en_i, .d_i({t_i, x0}), .q_o({t1, x1})
  );

  btpc_mul #(.WA(64), .WB(56)) u_mul_c0 (
    .clk_i, .en_i, .a_i(b0_q), .b_i(t1), .p_o(c0)
  );
  btpc_mul #(.WA(64), .WB(56)) u_mul_c1 (
    .clk_i, .en_i, .a_i(b1_q), .b_i(t1), .p_o(c1)
  );
  btpc_mul #(.WA(25), .WB(66)) u_mul_xc2 (
    .clk_i, .en_i, .a_i(x1), .b_i(c2_q), .p_o(xc2)
  );
  btpc_delay #(.W(81), .N(MulLat + 1)) u_dly_tx2 (
    .clk_i, .en_i, .d_i({t1, x1}), .q_o({t2, x2})
  );

  btpc_mul #(.WA(123), .WB(56)) u_mul_e0 (
    .clk_i, .en_i, .a_i(d0_q), .b_i(t2), .p_o(e0)
  );
  btpc_mul #(.WA(122), .WB(56)) u_mul_e1 (
    .clk_i, .en_i, .a_i(d1_q), .b_i(t2), .p_o(e1)
  );
  btpc_delay #(.W(91), .N(MulLat + 1)) u_dly_xc2 (
    .clk_i, .en_i, .d_i(xc2), .q_o(xc2_dly)
  );
  btpc_delay #(.W(25), .N(MulLat + 1)) u_dly_x3 (
    .clk_i, .en_i, .d_i(x2), .q_o(x3)
  );

  btpc_mul #(.WA(25), .WB(180)) u_mul_xr (
    .clk_i, .en_i, .a_i(x3), .b_i(r1_q), .p_o(xr)
  );
  btpc_delay #(.W(180), .N(MulLat)) u_dly_f0 (
    .clk_i, .en_i, .d_i(f0_q), .q_o(f0_dly)
  );

  assign total = 206'(signed'({f0_dly, 22'b0})) + 206'(xr);

  assign fl = signed'(31'(press_floor_i));
  assign ce = signed'(31'(press_ceiling_i));
  assign q1 = (q_q < fl) ? fl : q_q;
  assign q2 = (q1 > ce) ? ce : q1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b0_q    <= 64'(a0) + 64'(signed'({coef_i.p7, 55'b0}));
      b1_q    <= 64'(a1) + 64'(signed'({coef_i.p3, 53'b0}));
      c2_q    <= 66'(a2) + 66'(signed'({coef_i.p9, 48'b0})) + 66'(signed'({xp, 31'b0}));
      d0_q    <= 123'(c0) + 123'(signed'({1'b0, coef_i.p6, 105'b0}));
      d1_q    <= 122'(c1) + 122'(signed'({coef_i.p2, 104'b0}));
      f0_q    <= 180'(e0) + 180'(signed'({1'b0, coef_i.p5, 162'b0}));
      r1_q    <= 180'(e1) + 180'(signed'({coef_i.p1, 161'b0}))
                 + 180'(signed'({xc2_dly, 85'b0}));
      q_q     <= total[205:175];
      press_q <= q2[22:0];
    end
  end

  assign valid_o = v_q[PressLat-1];
  assign press_o = press_q;

endmodule

// ===== dv/baro_temp_pressure_compensation_top_tb.sv =====
// self-checking testbench for the barometric temperature and pressure compensation top level
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top_tb;
  import btpc_pkg::*;

  typedef logic signed [255:0] acc_t;

  class comp_scoreboard;
    logic [63:0]        cal_lo, cal_mid;
    logic [39:0]        cal_hi;
    logic signed [15:0] t_floor, t_ceil;
    logic [22:0]        p_floor, p_ceil;
    out_word_t          expected_q[$];
    int                 n_fail, n_in, n_out;
    int                 mode_seen[4];
    int                 n_t_clamped, n_p_clamped;

    function void reset_regs();
      cal_lo = '0; cal_mid = '0; cal_hi = '0;
      t_floor = -16'sd10240; t_ceil = 16'sd21760;
      p_floor = 23'd1920000; p_ceil = 23'd8000000;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        CFG_CALIB_LOW:     cal_lo = v;
        CFG_CALIB_MID:     cal_mid = v;
        CFG_CALIB_HIGH:    cal_hi = v[39:0];
        CFG_TEMP_FLOOR:    t_floor = v[15:0];
        CFG_TEMP_CEILING:  t_ceil = v[15:0];
        CFG_PRESS_FLOOR:   p_floor = v[22:0];
        CFG_PRESS_CEILING: p_ceil = v[22:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] cal_byte(int i);
      logic [167:0] all;
      all = {cal_hi, cal_mid, cal_lo};
      return all[8*i +: 8];
    endfunction

    function longint cu16(int i);
      return longint'({cal_byte(i + 1), cal_byte(i)});
    endfunction

    function longint cs16(int i);
      logic signed [15:0] s;
      s = {cal_byte(i + 1), cal_byte(i)};
      return longint'(s);
    endfunction

    function longint cs8(int i);
      logic signed [7:0] s;
      s = cal_byte(i);
      return longint'(s);
    endfunction

    function out_word_t compensate(in_word_t w);
      out_word_t r;
      longint d, tl, lo, hi, q;
      acc_t x, t, acc;
      r = '0;
      if (mode_e'(w.mode) == MODE_NONE) return r;
      d  = longint'(w.raw_temperature) - cu16(0) * 256;
      tl = d * cu16(2) * 262144 + d * d * cs8(4);
      lo = longint'(t_floor) * (64'sd1 <<< 40);
      hi = longint'(t_ceil) * (64'sd1 <<< 40);
      if (tl < lo || tl > hi) n_t_clamped++;
      if (tl < lo) tl = lo;
      if (tl > hi) tl = hi;
      if (mode_e'(w.mode) != MODE_PRESS) r.temperature_out = 16'(tl >>> 40);
      if (mode_e'(w.mode) == MODE_TEMP) return r;
      x = acc_t'(longint'(w.raw_pressure));
      t = acc_t'(tl);
      acc = (acc_t'(cu16(11)) <<< 184)
          + ((acc_t'(cu16(13)) * t) <<< 127)
          + ((acc_t'(cs8(15)) * t * t) <<< 77)
          + ((acc_t'(cs8(16)) * t * t * t) <<< 22)
          + ((x * acc_t'(cs16(5) - 16384)) <<< 161)
          + ((x * acc_t'(cs16(7) - 16384) * t) <<< 104)
          + ((x * acc_t'(cs8(9)) * t * t) <<< 53)
          + (x * acc_t'(cs8(10)) * t * t * t)
          + ((x * x * acc_t'(cs16(17))) <<< 133)
          + ((x * x * acc_t'(cs8(19)) * t) <<< 85)
          + ((x * x * x * acc_t'(cs8(20))) <<< 116);
      q = longint'(acc >>> 175);
      if (q < longint'(p_floor) || q > longint'(p_ceil)) n_p_clamped++;
      if (q < longint'(p_floor)) q = longint'(p_floor);
      if (q > longint'(p_ceil)) q = longint'(p_ceil);
      r.pressure_out = q[22:0];
      return r;
    endfunction

    function void note_word(in_word_t w);
      n_in++;
      mode_seen[w.mode]++;
      expected_q.push_back(compensate(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      n_out++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        n_fail++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.temperature_out !== exp_w.temperature_out) begin
        $error("temperature_out expected %0d got %0d", exp_w.temperature_out,
               got.temperature_out);
        n_fail++;
      end
      if (got.pressure_out !== exp_w.pressure_out) begin
        $error("pressure_out expected %0d got %0d", exp_w.pressure_out, got.pressure_out);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  comp_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  baro_temp_pressure_compensation_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i, .out_valid_o, .out_stall_i,
    .out_word_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_word(in_word_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_word_o);
  end

  // receiver side, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 200) hold_done <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 29);
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(in_word_t w);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t make_word(bit near);
    in_word_t w;
    w.mode = 2'($urandom_range(3));
    if (near) begin
      w.raw_temperature = 24'(sb.cu16(0) * 256 + $urandom_range(2000000) - 1000000);
      w.raw_pressure    = 24'($urandom_range(9000000, 5000000));
    end else begin
      w.raw_temperature = 24'($urandom);
      w.raw_pressure    = 24'($urandom);
    end
    return w;
  endfunction

  // plausible sensor calibration: T1 27504, T2 19072, T3 -7, P1..P11
  task automatic load_plausible();
    write_cfg(CFG_CALIB_LOW,   64'h9B_E6F8_F9_4A80_6B70);
    write_cfg(CFG_CALIB_MID,   64'h03_5B80_4DD8_00_F8_08);
    write_cfg(CFG_CALIB_HIGH,  64'hC4_0D_FFE0_FA);
  endtask

  initial begin
    int k;
    sb.reset_regs();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset calibration then a plausible one
    for (k = 0; k < 4; k++) begin
      send_word('{mode: k[1:0], raw_pressure: 24'h000000, raw_temperature: 24'h000000});
      send_word('{mode: k[1:0], raw_pressure: 24'hFFFFFF, raw_temperature: 24'hFFFFFF});
    end
    drain();
    load_plausible();
    for (k = 0; k < 4; k++) begin
      send_word('{mode: k[1:0], raw_pressure: 24'h000000, raw_temperature: 24'h000000});
      send_word('{mode: k[1:0], raw_pressure: 24'hFFFFFF, raw_temperature: 24'hFFFFFF});
      send_word('{mode: k[1:0], raw_pressure: 24'd6500000, raw_temperature: 24'd7041024});
    end
    drain();
    // floor above ceiling
    write_cfg(CFG_TEMP_FLOOR, 64'h0000_0000_0000_1000);
    write_cfg(CFG_TEMP_CEILING, 64'hFFFF_FFFF_FFFF_F000);
    write_cfg(CFG_PRESS_FLOOR, 64'd7000000);
    write_cfg(CFG_PRESS_CEILING, 64'd10);
    send_word('{mode: MODE_BOTH, raw_pressure: 24'd6500000, raw_temperature: 24'd7041024});
    send_word('{mode: MODE_PRESS, raw_pressure: 24'd100, raw_temperature: 24'd7000000});
    drain();

    // widest clamps, plausible calibration
    write_cfg(CFG_TEMP_FLOOR, 64'hABCD_0000_0000_8000);
    write_cfg(CFG_TEMP_CEILING, 64'h1234_0000_0000_7FFF);
    write_cfg(CFG_PRESS_FLOOR, 64'hFF00_0000_0000_0000);
    write_cfg(CFG_PRESS_CEILING, 64'h0000_0000_FF7F_FFFF);
    quiet = 1'b1;
    repeat (150) send_word(make_word(1'b1));
    quiet = 1'b0;
    repeat (300) send_word(make_word($urandom_range(99) < 80));
    hold_go = 1'b1;
    repeat (150) send_word(make_word(1'b1));
    drain();

    // random calibration and clamps, several settings
    repeat (4) begin
      write_cfg(CFG_CALIB_LOW, rnd64());
      write_cfg(CFG_CALIB_MID, rnd64());
      write_cfg(CFG_CALIB_HIGH, rnd64());
      write_cfg(CFG_TEMP_FLOOR, rnd64());
      write_cfg(CFG_TEMP_CEILING, rnd64());
      write_cfg(CFG_PRESS_FLOOR, rnd64());
      write_cfg(CFG_PRESS_CEILING, rnd64());
      repeat (100) send_word(make_word($urandom_range(1) == 1));
      drain();
    end
    load_plausible();
    write_cfg(CFG_TEMP_FLOOR, 64'($urandom_range(65535)));
    write_cfg(CFG_TEMP_CEILING, 64'h7FFF);
    write_cfg(CFG_PRESS_FLOOR, 64'd0);
    write_cfg(CFG_PRESS_CEILING, 64'h7FFFFF);
    repeat (360) send_word(make_word($urandom_range(99) < 85));
    drain();

    $display("covered %0d words in, %0d results; modes none/temp/press/both %0d/%0d/%0d/%0d",
             sb.n_in, sb.n_out, sb.mode_seen[0], sb.mode_seen[1], sb.mode_seen[2],
             sb.mode_seen[3]);
    $display("temperature clamps hit %0d times, pressure clamps %0d times",
             sb.n_t_clamped, sb.n_p_clamped);
    if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/btpc_pkg.sv
sv/btpc_delay.sv
sv/btpc_mul.sv
sv/btpc_temp.sv
sv/btpc_press.sv
sv/baro_temp_pressure_compensation_top.sv
dv/baro_temp_pressure_compensation_top_tb.sv
